[rtl/address_map_region_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the address map region decoder
// Implication checks sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_MAP_REGION_DECODER_CORE_MACROS_SVH
`define ADDRESS_MAP_REGION_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AMRDEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decoder check failed");
// next-cycle implication
`define AMRDEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decoder check failed");
`else
`define AMRDEC_ASSERT_IMP(lbl, ante, cons)
`define AMRDEC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/amrdec_pkg.sv]
// ----------------------------------------------------------------------------
// Address map region decoder package
// Codes, defaults and the word that travels down the region cell chain.
// ----------------------------------------------------------------------------
package amrdec_pkg;

  localparam int MaxRegionsDefault = 8;
  localparam int StoreBytesDefault = 65536;
  localparam logic [17:0] SPACE_END = 18'h10000;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BEYOND  = 3'd1,
    ST_OVERLAP = 3'd2,
    ST_FULL    = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  // word handed from cell to cell
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [15:0] address;
    logic [16:0] size;
    logic        rd;
    logic        wr;
    logic [7:0]  wdata;
    logic        trap;
    status_t     status;
    logic        hit;
    logic        handled;
    logic        placed;
    logic [2:0]  idx;
  } tok_t;

  typedef struct packed {
    logic        done;
    status_t     status;
    logic        routed;
    logic [2:0]  idx;
    logic [7:0]  rdata;
    logic [15:0] daddr;
    logic [7:0]  ddata;
    logic        dtrap;
  } res_t;

endpackage

[rtl/amrdec_cell.sv]
// ----------------------------------------------------------------------------
// Region cell
// Holds one region entry; checks the passing word for hit, overlap or claim.
// ----------------------------------------------------------------------------
module amrdec_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  amrdec_pkg::tok_t   tok_i,
  output amrdec_pkg::tok_t   tok_o
);
  import amrdec_pkg::*;

  logic        valid;
  logic [15:0] start;
  logic [16:0] length;
  logic        rd;
  logic        wr;

  logic [16:0] reg_end;
  logic [17:0] new_end;
  logic        in_region;
  logic        overlap;
  logic        capture;
  tok_t        tok_next;

  assign reg_end   = {1'b0, start} + length;
  assign new_end   = {2'b00, tok_i.address} + {1'b0, tok_i.size};
  assign in_region = (tok_i.address >= start) && ({1'b0, tok_i.address} < reg_end);
  assign overlap   = ({1'b0, tok_i.address} < reg_end) && ({2'b00, start} < new_end);
  assign capture   = tok_i.vld && (tok_i.op == OP_MAP) && (tok_i.status == ST_OK) &&
                     !tok_i.placed && !valid;

  always_comb begin
    tok_next = tok_i;
    if (tok_i.vld) begin
      unique case (tok_i.op)
        OP_MAP: begin
          if (tok_i.status == ST_OK && !tok_i.placed) begin
            if (valid && overlap) begin
              tok_next.status = ST_OVERLAP;
            end else if (!valid) begin
              tok_next.placed = 1'b1;
              tok_next.idx    = 3'(CELL_IDX);
            end
          end
        end
        OP_READ, OP_WRITE: begin
          if (valid && in_region && !tok_i.hit) begin
            tok_next.hit     = 1'b1;
            tok_next.idx     = 3'(CELL_IDX);
            tok_next.handled = (tok_i.op == OP_READ) ? rd : wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_o <= '0;
      valid <= 1'b0;
    end else begin
      tok_o <= tok_next;
      if (capture) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      start  <= tok_i.address;
      length <= tok_i.size;
      rd     <= tok_i.rd;
      wr     <= tok_i.wr;
    end
  end

endmodule

[rtl/amrdec_store.sv]
// ----------------------------------------------------------------------------
// Backing store and result stage
// Byte memory with a clearing pass after reset; forms the result word.
// ----------------------------------------------------------------------------
module amrdec_store #(
  parameter int STORE_BYTES = amrdec_pkg::StoreBytesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  amrdec_pkg::tok_t   tok_i,
  output logic               clearing,
  output amrdec_pkg::res_t   res
);
  import amrdec_pkg::*;

  localparam int SA_W = $clog2(STORE_BYTES);

  logic [7:0]      mem [STORE_BYTES];
  logic [SA_W-1:0] clr_addr;
  logic [7:0]      mem_q;
  tok_t            s_tok;
  logic            s_beyond;
  logic            s_rd;

  logic beyond;
  logic rw;
  logic acc;

  assign beyond = {1'b0, tok_i.address} >= 17'(STORE_BYTES);
  assign rw     = (tok_i.op == OP_READ) || (tok_i.op == OP_WRITE);
  assign acc    = tok_i.vld && rw && !tok_i.handled && !beyond;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SA_W'(STORE_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (acc && tok_i.op == OP_WRITE) begin
      mem[tok_i.address[SA_W-1:0]] <= tok_i.wdata;
    end
    if (acc && tok_i.op == OP_READ) begin
      mem_q <= mem[tok_i.address[SA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tok <= '0;
    end else begin
      s_tok <= tok_i;
    end
    s_beyond <= beyond;
    s_rd     <= acc && (tok_i.op == OP_READ);
  end

  always_comb begin
    res      = '0;
    res.done = s_tok.vld;
    if (s_tok.vld) begin
      unique case (s_tok.op)
        OP_MAP: begin
          if (s_tok.placed) begin
            res.status = ST_OK;
            res.idx    = s_tok.idx;
          end else if (s_tok.status != ST_OK) begin
            res.status = s_tok.status;
          end else begin
            res.status = ST_FULL;
          end
        end
        OP_READ, OP_WRITE: begin
          res.idx    = s_tok.hit ? s_tok.idx : 3'd0;
          res.routed = s_tok.handled;
          if (s_tok.handled) begin
            res.daddr = s_tok.address;
            res.ddata = (s_tok.op == OP_WRITE) ? s_tok.wdata : 8'h00;
            res.dtrap = (s_tok.op == OP_READ) && s_tok.trap;
          end else if (s_beyond) begin
            res.status = ST_BEYOND;
          end
          res.rdata = s_rd ? mem_q : 8'h00;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/address_map_region_decoder_core.sv]
// ----------------------------------------------------------------------------
// Address map region decoder core
// Region table as a chain of cells in front of a byte backing store.
// ----------------------------------------------------------------------------
// Flow: an accepted word is registered in head, walks the cell chain one
// region per cycle, is registered once more in the store stage, and done
// then rises; busy drops at the edge that ends the done cycle, and only
// then can a new word be accepted.
// Reset: region table empties at once; the store is then cleared one byte a
// cycle with busy high. The receiver cannot stall.
`include "address_map_region_decoder_core_macros.svh"

module address_map_region_decoder_core #(
  parameter int MAX_REGIONS = amrdec_pkg::MaxRegionsDefault,
  parameter int STORE_BYTES = amrdec_pkg::StoreBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [16:0] range_size,
  input  logic        has_read_handler,
  input  logic        has_write_handler,
  input  logic [7:0]  write_data,
  input  logic        trap_flag,
  output logic        done,
  output logic [2:0]  status,
  output logic        routed_to_region,
  output logic [2:0]  region_index,
  output logic [7:0]  read_data,
  output logic [15:0] device_address,
  output logic [7:0]  device_data,
  output logic        device_trap
);
  import amrdec_pkg::*;

  tok_t  chain [MAX_REGIONS+1];
  tok_t  head;
  tok_t  entry;
  res_t  res;
  logic  clearing;
  logic  inflight;
  logic  accept;
  logic [17:0] map_end;

  assign accept  = start && !busy;
  assign busy    = clearing || inflight;
  assign map_end = {2'b00, address} + {1'b0, range_size};

  always_comb begin
    entry         = '0;
    entry.vld     = 1'b1;
    entry.op      = op_t'(opcode);
    entry.address = address;
    entry.size    = range_size;
    entry.rd      = has_read_handler;
    entry.wr      = has_write_handler;
    entry.wdata   = write_data;
    entry.trap    = trap_flag;
    entry.status  = ST_OK;
    if (op_t'(opcode) == OP_MAP) begin
      priority if (range_size == 17'd0) begin
        entry.status = ST_ZERO;
      end else if (map_end > SPACE_END) begin
        entry.status = ST_BEYOND;
      end else begin
        entry.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      inflight <= 1'b0;
    end else begin
      head <= accept ? entry : '0;
      if (accept) begin
        inflight <= 1'b1;
      end else if (res.done) begin
        inflight <= 1'b0;
      end
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    amrdec_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  amrdec_store #(
    .STORE_BYTES (STORE_BYTES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .tok_i    (chain[MAX_REGIONS]),
    .clearing (clearing),
    .res      (res)
  );

  assign done             = res.done;
  assign status           = res.status;
  assign routed_to_region = res.routed;
  assign region_index     = res.idx;
  assign read_data        = res.rdata;
  assign device_address   = res.daddr;
  assign device_data      = res.ddata;
  assign device_trap      = res.dtrap;

  `AMRDEC_ASSERT_NXT(a_accept_busy, accept, busy)
  `AMRDEC_ASSERT_NXT(a_done_single, done, !done)
  `AMRDEC_ASSERT_IMP(a_routed_no_store, done && routed_to_region, read_data == 8'h00)
  `AMRDEC_ASSERT_IMP(a_routed_ok, done && routed_to_region, status == ST_OK)

endmodule
